// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, action codes, request and response types for the core; the
// widths are also shared by its pipelined divider.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // magnitude of a denominator or numerator from the Smith stage
   localparam int MAG_W   = WORD_BITS + 1;
   // dividend: magnitude shifted up by the fraction bits
   localparam int DVD_W   = MAG_W + FRAC_BITS;
   localparam int QUO_W   = WORD_BITS;
   // one register stage for the range check, one per quotient bit
   localparam int DIV_LAT = QUO_W + 1;
   // product of two words and its sum before the fraction bits drop
   localparam int PROD_W  = 2 * WORD_BITS;
   localparam int CLIP_W  = PROD_W + 1 - FRAC_BITS;
   // Smith ratio: magnitude up to one, plus sign
   localparam int RAT_W   = FRAC_BITS + 2;
   localparam int NUM_W   = WORD_BITS + 2;
   localparam int PIPE_LAT = 2 * DIV_LAT + 7;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                  action;
      logic signed [WORD_BITS-1:0] a_real;
      logic signed [WORD_BITS-1:0] a_imag;
      logic signed [WORD_BITS-1:0] b_real;
      logic signed [WORD_BITS-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic                        divide_by_zero;
      logic                        saturated;
   } rsp_type;

endpackage

// ===== rtl/cau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage. Flags quotients that do
// not fit in QUO_W bits (and a zero divisor).
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DVD_W-1:0] in_dvd,
   input  logic [MAG_W-1:0] in_dvs,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_ovf
);

   logic             vld_ff [0:QUO_W];
   logic [MAG_W-1:0] rem_ff [0:QUO_W];
   logic [MAG_W-1:0] dvs_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   logic [MAG_W-1:0] top_in;

   // quotient fits iff the upper dividend bits stay below the divisor
   assign top_in = MAG_W'(in_dvd[DVD_W-1:QUO_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= top_in;
      dvs_ff[0] <= in_dvs;
      low_ff[0] <= in_dvd[QUO_W-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= (top_in >= in_dvs);
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      logic [MAG_W:0]   trial;
      logic             ge;
      logic [MAG_W-1:0] rem_in;

      assign trial  = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
      assign ge     = (trial >= {1'b0, dvs_ff[k-1]});
      assign rem_in = ge ? MAG_W'(trial - {1'b0, dvs_ff[k-1]}) : trial[MAG_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         dvs_ff[k] <= dvs_ff[k-1];
         low_ff[k] <= {low_ff[k-1][QUO_W-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], ge};
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##DIV_LAT out_valid)
      else $error("divider lost a request");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ovf |-> rem_ff[QUO_W] < dvs_ff[QUO_W])
      else $error("divider remainder not below divisor");

   a_div_small: assert property (@(posedge clock) disable iff (reset)
      in_valid && (in_dvd < DVD_W'(in_dvs)) |-> ##DIV_LAT (out_quo == '0 && !out_ovf))
      else $error("divider quotient nonzero for small dividend");

endmodule

// ===== rtl/complex_arith_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and Smith divide of signed Q16.16 complex values,
// saturated to the word range.
//
//   channel  ports                       direction  handshake
//   request  start, busy, req_data       in         start && !busy
//   response rsp_valid, rsp_data         out        one-cycle strobe
//
// One request per cycle, every cycle that busy is low. Each request passes
// through two 33-stage dividers in series (ratio, then quotients) plus
// seven single stages (request, products, ratio sign, ratio products,
// numerators, magnitudes, output).
// Reset clears all valid bits; busy is high during reset only.
// No stalls: the response side always takes the result.
// ----------------------------------------------------------------------------
module complex_arith_unit_core import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [1:0]                  act;
      logic signed [WORD_BITS-1:0] ar;
      logic signed [WORD_BITS-1:0] ai;
      logic signed [WORD_BITS-1:0] big;
      logic signed [WORD_BITS-1:0] small_part;
      logic                        sel;
      logic                        neg;
      logic                        dz;
      logic [WORD_BITS-1:0]        e_r;
      logic [WORD_BITS-1:0]        e_i;
      logic                        e_sat;
   } side1_type;

   typedef struct packed {
      logic [1:0]           act;
      logic                 dz;
      logic [WORD_BITS-1:0] e_r;
      logic [WORD_BITS-1:0] e_i;
      logic                 e_sat;
      logic                 sgn_r;
      logic                 sgn_i;
   } side2_type;

   function automatic logic [WORD_BITS:0] clip_word(input logic signed [CLIP_W-1:0] x);
      logic fits;
      fits = (&x[CLIP_W-1:WORD_BITS-1]) || !(|x[CLIP_W-1:WORD_BITS-1]);
      if (fits) clip_word = {1'b0, x[WORD_BITS-1:0]};
      else      clip_word = {1'b1, x[CLIP_W-1] ? WORD_MIN : WORD_MAX};
   endfunction

   // sign-applied quotient with saturation
   function automatic logic [WORD_BITS:0] quo_fix(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
      if (neg) begin
         if (ovf || q > WORD_MIN) quo_fix = {1'b1, WORD_MIN};
         else                     quo_fix = {1'b0, WORD_BITS'(~q + 1'b1)};
      end else begin
         if (ovf || q[QUO_W-1]) quo_fix = {1'b1, WORD_MAX};
         else                   quo_fix = {1'b0, q};
      end
   endfunction

   function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] x);
      mag_word = x[WORD_BITS-1] ? WORD_BITS'(~x + 1'b1) : x;
   endfunction

   assign busy = reset;

   // ---------------- stage 1: request register
   logic    v1_ff;
   req_type op1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff <= req_data;
   end

   // ---------------- stage 2: products, sums, magnitudes
   logic                        v2_ff;
   logic [1:0]                  act2_ff;
   logic signed [WORD_BITS-1:0] ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [PROD_W-1:0]    prr_a_ff, prr_b_ff, pri_a_ff, pri_b_ff;
   logic signed [WORD_BITS:0]   sr2_ff, si2_ff;
   logic [WORD_BITS-1:0]        mbr2_ff, mbi2_ff;
   logic                        dz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      act2_ff  <= op1_ff.action;
      ar2_ff   <= op1_ff.a_real;
      ai2_ff   <= op1_ff.a_imag;
      br2_ff   <= op1_ff.b_real;
      bi2_ff   <= op1_ff.b_imag;
      prr_a_ff <= op1_ff.a_real * op1_ff.b_real;
      prr_b_ff <= op1_ff.a_imag * op1_ff.b_imag;
      pri_a_ff <= op1_ff.a_real * op1_ff.b_imag;
      pri_b_ff <= op1_ff.a_imag * op1_ff.b_real;
      if (op1_ff.action == ACT_SUB) begin
         sr2_ff <= (WORD_BITS+1)'(op1_ff.a_real) - (WORD_BITS+1)'(op1_ff.b_real);
         si2_ff <= (WORD_BITS+1)'(op1_ff.a_imag) - (WORD_BITS+1)'(op1_ff.b_imag);
      end else begin
         sr2_ff <= (WORD_BITS+1)'(op1_ff.a_real) + (WORD_BITS+1)'(op1_ff.b_real);
         si2_ff <= (WORD_BITS+1)'(op1_ff.a_imag) + (WORD_BITS+1)'(op1_ff.b_imag);
      end
      mbr2_ff <= mag_word(op1_ff.b_real);
      mbi2_ff <= mag_word(op1_ff.b_imag);
      dz2_ff  <= (op1_ff.action == ACT_DIV) && (op1_ff.b_real == '0)
                 && (op1_ff.b_imag == '0);
   end

   // ---------------- stage 3: early results, ratio division issue
   logic                      sel3;
   logic signed [PROD_W:0]    mre3, mim3;
   logic [WORD_BITS:0]        cr3, ci3;
   side1_type                 side1_in;
   logic [DVD_W-1:0]          dvd1;
   logic [MAG_W-1:0]          dvs1;

   always_comb begin
      sel3 = (mbr2_ff >= mbi2_ff);   // tie takes the real branch
      mre3 = (PROD_W+1)'(prr_a_ff) - (PROD_W+1)'(prr_b_ff);
      mim3 = (PROD_W+1)'(pri_a_ff) + (PROD_W+1)'(pri_b_ff);
      if (act2_ff == ACT_MUL) begin
         cr3 = clip_word(mre3[PROD_W:FRAC_BITS]);
         ci3 = clip_word(mim3[PROD_W:FRAC_BITS]);
      end else begin
         cr3 = clip_word(CLIP_W'(sr2_ff));
         ci3 = clip_word(CLIP_W'(si2_ff));
      end
      side1_in.act        = act2_ff;
      side1_in.ar         = ar2_ff;
      side1_in.ai         = ai2_ff;
      side1_in.big        = sel3 ? br2_ff : bi2_ff;
      side1_in.small_part = sel3 ? bi2_ff : br2_ff;
      side1_in.sel        = sel3;
      side1_in.neg        = br2_ff[WORD_BITS-1] ^ bi2_ff[WORD_BITS-1];
      side1_in.dz         = dz2_ff;
      side1_in.e_r        = cr3[WORD_BITS-1:0];
      side1_in.e_i        = ci3[WORD_BITS-1:0];
      side1_in.e_sat      = cr3[WORD_BITS] | ci3[WORD_BITS];
      dvd1 = {1'b0, sel3 ? mbi2_ff : mbr2_ff, {FRAC_BITS{1'b0}}};
      dvs1 = {1'b0, sel3 ? mbr2_ff : mbi2_ff};
   end

   logic             d1_valid, d1_ovf;
   logic [QUO_W-1:0] d1_quo;

   cau_div u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_dvd    (dvd1),
      .in_dvs    (dvs1),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_ovf   (d1_ovf)
   );

   side1_type side1_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      side1_ff[0] <= side1_in;
      for (int k = 1; k < DIV_LAT; k++) side1_ff[k] <= side1_ff[k-1];
   end

   // ---------------- stage 4: signed ratio
   logic                    v4_ff;
   logic signed [RAT_W-1:0] rat4_ff;
   side1_type               side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= d1_valid;
      end
   end

   // ratio never exceeds one; its range flag only blocks the sign flip
   always_ff @(posedge clock) begin
      if (side1_ff[DIV_LAT-1].neg && !d1_ovf) begin
         rat4_ff <= RAT_W'(-$signed({1'b0, d1_quo[FRAC_BITS:0]}));
      end else begin
         rat4_ff <= $signed({1'b0, d1_quo[FRAC_BITS:0]});
      end
      side4_ff <= side1_ff[DIV_LAT-1];
   end

   // ---------------- stage 5: ratio products
   logic                                v5_ff;
   logic signed [RAT_W+WORD_BITS-1:0]   pd5_ff, pa5_ff, pi5_ff;
   side1_type                           side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      pd5_ff   <= rat4_ff * side4_ff.small_part;
      pa5_ff   <= rat4_ff * side4_ff.ar;
      pi5_ff   <= rat4_ff * side4_ff.ai;
      side5_ff <= side4_ff;
   end

   // ---------------- stage 6: scaled denominator and numerators
   logic                    v6_ff;
   logic signed [NUM_W-1:0] den6_ff, nr6_ff, ni6_ff;
   side1_type               side6_ff;
   logic signed [NUM_W-1:0] fd6, fa6, fi6, ar6, ai6;

   always_comb begin
      fd6 = pd5_ff[RAT_W+WORD_BITS-1:FRAC_BITS];
      fa6 = pa5_ff[RAT_W+WORD_BITS-1:FRAC_BITS];
      fi6 = pi5_ff[RAT_W+WORD_BITS-1:FRAC_BITS];
      ar6 = NUM_W'(side5_ff.ar);
      ai6 = NUM_W'(side5_ff.ai);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      den6_ff <= NUM_W'(side5_ff.big) + fd6;
      if (side5_ff.sel) begin
         nr6_ff <= ar6 + fi6;
         ni6_ff <= ai6 - fa6;
      end else begin
         nr6_ff <= fa6 + ai6;
         ni6_ff <= fi6 - ar6;
      end
      side6_ff <= side5_ff;
   end

   // ---------------- stage 7: magnitudes for the quotient dividers
   logic              v7_ff;
   logic [MAG_W-1:0]  mnr7_ff, mni7_ff, mden7_ff;
   side2_type         side7_ff;
   logic [NUM_W-1:0]  mnr_in, mni_in, mden_in;

   always_comb begin
      mnr_in  = nr6_ff[NUM_W-1]  ? NUM_W'(~nr6_ff + 1'b1)  : nr6_ff;
      mni_in  = ni6_ff[NUM_W-1]  ? NUM_W'(~ni6_ff + 1'b1)  : ni6_ff;
      mden_in = den6_ff[NUM_W-1] ? NUM_W'(~den6_ff + 1'b1) : den6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      mnr7_ff        <= mnr_in[MAG_W-1:0];
      mni7_ff        <= mni_in[MAG_W-1:0];
      mden7_ff       <= mden_in[MAG_W-1:0];
      side7_ff.act   <= side6_ff.act;
      side7_ff.dz    <= side6_ff.dz
                        || (side6_ff.act == ACT_DIV && den6_ff == '0);
      side7_ff.e_r   <= side6_ff.e_r;
      side7_ff.e_i   <= side6_ff.e_i;
      side7_ff.e_sat <= side6_ff.e_sat;
      side7_ff.sgn_r <= nr6_ff[NUM_W-1] ^ den6_ff[NUM_W-1];
      side7_ff.sgn_i <= ni6_ff[NUM_W-1] ^ den6_ff[NUM_W-1];
   end

   logic             dr_valid, dr_ovf, di_valid, di_ovf;
   logic [QUO_W-1:0] dr_quo, di_quo;

   cau_div u_div_real (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_dvd    ({mnr7_ff, {FRAC_BITS{1'b0}}}),
      .in_dvs    (mden7_ff),
      .out_valid (dr_valid),
      .out_quo   (dr_quo),
      .out_ovf   (dr_ovf)
   );

   cau_div u_div_imag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_dvd    ({mni7_ff, {FRAC_BITS{1'b0}}}),
      .in_dvs    (mden7_ff),
      .out_valid (di_valid),
      .out_quo   (di_quo),
      .out_ovf   (di_ovf)
   );

   side2_type side2_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      side2_ff[0] <= side7_ff;
      for (int k = 1; k < DIV_LAT; k++) side2_ff[k] <= side2_ff[k-1];
   end

   // ---------------- output stage
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   side2_type          sd;
   logic [WORD_BITS:0] qr, qi;
   rsp_type            rsp_in;

   always_comb begin
      sd = side2_ff[DIV_LAT-1];
      qr = quo_fix(dr_quo, dr_ovf, sd.sgn_r);
      qi = quo_fix(di_quo, di_ovf, sd.sgn_i);
      if (sd.act != ACT_DIV) begin
         rsp_in.res_real       = sd.e_r;
         rsp_in.res_imag       = sd.e_i;
         rsp_in.divide_by_zero = 1'b0;
         rsp_in.saturated      = sd.e_sat;
      end else if (sd.dz) begin
         rsp_in.res_real       = '0;
         rsp_in.res_imag       = '0;
         rsp_in.divide_by_zero = 1'b1;
         rsp_in.saturated      = 1'b0;
      end else begin
         rsp_in.res_real       = qr[WORD_BITS-1:0];
         rsp_in.res_imag       = qi[WORD_BITS-1:0];
         rsp_in.divide_by_zero = 1'b0;
         rsp_in.saturated      = qr[WORD_BITS] | qi[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dr_valid & di_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_dz_other: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action != ACT_DIV
      |-> ##PIPE_LAT (rsp_valid && !rsp_data.divide_by_zero))
      else $error("non-divide request lost or flagged divide by zero");

   a_dz_zero_div: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACT_DIV && req_data.b_real == '0
      && req_data.b_imag == '0 |-> ##PIPE_LAT (rsp_valid && rsp_data.divide_by_zero))
      else $error("zero divisor not flagged");

   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero
      |-> rsp_data.res_real == '0 && rsp_data.res_imag == '0 && !rsp_data.saturated)
      else $error("divide by zero result not cleared");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends add, subtract, multiply and divide requests with random gaps, works
// out each expected response bit for bit from a local fixed-point model and
// checks every response strobe against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
   import cau_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_results[$];
   int      error_count;
   int      cycle_count;
   int      request_count;
   int      response_count;
   int      div_zero_seen;
   int      sat_seen;
   int      action_count[4];

   complex_arith_unit_core dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // fixed-point model; 96-bit intermediates keep every sum exact
   function automatic rsp_type predict_result(req_type r);
      logic signed [95:0] ar, ai, br, bi, rr, ri, ratio, den, nr, ni, mag_r, mag_i;
      logic signed [95:0] hi_lim, lo_lim;
      rsp_type            res;
      ar = r.a_real;
      ai = r.a_imag;
      br = r.b_real;
      bi = r.b_imag;
      rr = 0;
      ri = 0;
      res = '0;
      hi_lim = 96'sd2147483647;
      lo_lim = -96'sd2147483648;
      case (r.action)
         ACT_ADD: begin
            rr = ar + br;
            ri = ai + bi;
         end
         ACT_SUB: begin
            rr = ar - br;
            ri = ai - bi;
         end
         ACT_MUL: begin
            rr = (ar * br - ai * bi) >>> FRAC_BITS;
            ri = (ar * bi + ai * br) >>> FRAC_BITS;
         end
         default: begin
            if (br == 0 && bi == 0) begin
               res.divide_by_zero = 1'b1;
            end else begin
               mag_r = (br < 0) ? -br : br;
               mag_i = (bi < 0) ? -bi : bi;
               // ties go to the real-part branch
               if (mag_r >= mag_i) begin
                  ratio = (bi * 96'sd65536) / br;
                  den = br + ((ratio * bi) >>> FRAC_BITS);
                  nr = ar + ((ratio * ai) >>> FRAC_BITS);
                  ni = ai - ((ratio * ar) >>> FRAC_BITS);
               end else begin
                  ratio = (br * 96'sd65536) / bi;
                  den = bi + ((ratio * br) >>> FRAC_BITS);
                  nr = ((ar * ratio) >>> FRAC_BITS) + ai;
                  ni = ((ai * ratio) >>> FRAC_BITS) - ar;
               end
               if (den == 0) begin
                  res.divide_by_zero = 1'b1;
               end else begin
                  rr = (nr * 96'sd65536) / den;
                  ri = (ni * 96'sd65536) / den;
               end
            end
         end
      endcase
      if (rr > hi_lim) begin rr = hi_lim; res.saturated = 1'b1; end
      if (rr < lo_lim) begin rr = lo_lim; res.saturated = 1'b1; end
      if (ri > hi_lim) begin ri = hi_lim; res.saturated = 1'b1; end
      if (ri < lo_lim) begin ri = lo_lim; res.saturated = 1'b1; end
      res.res_real = rr[WORD_BITS-1:0];
      res.res_imag = ri[WORD_BITS-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("tb: mismatch on %s at cycle %0d: got %h want %h",
               field, cycle_count, got, want);
   endtask

   // checks each response strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         response_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("tb: unexpected response at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.res_real !== want.res_real)
               report_mismatch("res_real", rsp_data.res_real, want.res_real);
            if (rsp_data.res_imag !== want.res_imag)
               report_mismatch("res_imag", rsp_data.res_imag, want.res_imag);
            if (rsp_data.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", 32'(rsp_data.divide_by_zero),
                               32'(want.divide_by_zero));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp_data.saturated),
                               32'(want.saturated));
            if (want.divide_by_zero) div_zero_seen++;
            if (want.saturated) sat_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // sends one request after a gap; start stays high on return
   task automatic send_request(req_type r, int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_results.push_back(predict_result(r));
      action_count[r.action]++;
      request_count++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         4, 5: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_request(logic [1:0] act, logic [31:0] ar,
                                            logic [31:0] ai, logic [31:0] br,
                                            logic [31:0] bi);
      req_type r;
      r.action = act;
      r.a_real = ar;
      r.a_imag = ai;
      r.b_real = br;
      r.b_imag = bi;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [1:0] acts[4];
      acts = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV};
      foreach (acts[k]) begin
         send_request(make_request(acts[k], WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN), 0);
         send_request(make_request(acts[k], WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX), 0);
         send_request(make_request(acts[k], 32'h0003_8000, 32'hfffe_4000,
                                   32'h0001_0000, 32'h0002_0000), 0);
      end
      // zero divisor
      send_request(make_request(ACT_DIV, WORD_MAX, 32'h0001_0000, 32'd0, 32'd0), 0);
      // divisor parts of equal magnitude, both signs
      send_request(make_request(ACT_DIV, 32'h0005_0000, 32'h0002_0000,
                                32'h0003_0000, 32'hfffd_0000), 1);
      send_request(make_request(ACT_DIV, 32'h0005_0000, 32'h0002_0000,
                                WORD_MIN, WORD_MIN), 0);
      // tiny divisors; the first overflows the quotient
      send_request(make_request(ACT_DIV, WORD_MAX, WORD_MIN, 32'd1, 32'd0), 0);
      send_request(make_request(ACT_DIV, 32'h0000_0100, 32'd0, 32'd0, 32'd1), 0);
      // multiply overflow, real-only operands and a zero dividend
      send_request(make_request(ACT_MUL, WORD_MIN, 32'd0, WORD_MIN, 32'd0), 0);
      send_request(make_request(ACT_MUL, 32'h0002_0000, 32'd0, 32'hffff_8000, 32'd0), 0);
      send_request(make_request(ACT_DIV, 32'd0, 32'd0, WORD_MAX, 32'd1), 2);
      go_idle();
      wait_drained();
   endtask

   task automatic test_random(int n);
      req_type    r;
      logic [1:0] act;
      int         gap;
      for (int k = 0; k < n; k++) begin
         act = 2'($urandom_range(0, 3));
         r = make_request(act, rand_word(), rand_word(), rand_word(), rand_word());
         // runs of back-to-back requests between stretches of random gaps
         gap = ((k / 100) % 2 == 0) ? $urandom_range(0, 16) : 0;
         send_request(r, gap);
      end
      go_idle();
   endtask

   task automatic test_pause_until_drained();
      go_idle();
      wait_drained();
      repeat ($urandom_range(0, 16)) @(negedge clock);
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      error_count = 0;
      cycle_count = 0;
      request_count = 0;
      response_count = 0;
      div_zero_seen = 0;
      sat_seen = 0;
      action_count = '{0, 0, 0, 0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(700);
      test_pause_until_drained();
      test_random(725);
      wait_drained();
      repeat (PIPE_LAT + 20) @(posedge clock);

      $display("tb: %0d requests, %0d responses (add %0d sub %0d mul %0d div %0d)",
               request_count, response_count, action_count[0], action_count[1],
               action_count[2], action_count[3]);
      $display("tb: zero divisors %0d, saturated results %0d", div_zero_seen, sat_seen);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== complex_arith_unit_core.f =====
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arith_unit_core.sv
tb/tb.sv
